// File: hw/rtl/ftm_pkg.sv
// ----------------------------------------------------------------------------
// ftm_pkg: shared types and constants of the filmic tone mapper
// Pixel payload structs, register indexes and fixed output scaling.
// ----------------------------------------------------------------------------
package ftm_pkg;

  // Fraction bits of the linear input and white point format.
  localparam int unsigned FracBits = 16;
  // Bits of one output channel.
  localparam int unsigned OutBits = 8;
  // Full-scale output code.
  localparam int unsigned OutMax = (1 << OutBits) - 1;
  // Width of the curve value, an unsigned Q0.32.
  localparam int unsigned CurveBits = 32;

  // Configuration register indexes.
  localparam logic CFG_EXPOSURE_GAIN = 1'b0;
  localparam logic CFG_WHITE_POINT   = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [15:0] GainReset  = 16'd6554;
  localparam logic [23:0] WhiteReset = 24'd734003;

  typedef struct packed {
    logic [23:0] red_in;
    logic [23:0] green_in;
    logic [23:0] blue_in;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       clipped;
  } pixel_out_t;

endpackage

// File: hw/rtl/ftm_curve.sv
// ----------------------------------------------------------------------------
// ftm_curve: filmic curve lane
// Squares the scaled value, forms the curve numerator and denominator, then
// divides them in a 32-stage restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ftm_curve #(
  parameter int unsigned XW = 28
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  logic [XW-1:0]                   x_i,
  output logic                            valid_o,
  output logic [ftm_pkg::CurveBits-1:0]   g_o
);

  localparam int unsigned GW   = ftm_pkg::CurveBits;
  localparam int unsigned SQW  = 2 * XW - 16;
  localparam int unsigned M1   = (SQW + 6 > XW + 8) ? SQW + 6 : XW + 8;
  localparam int unsigned M2   = (M1 > 21) ? M1 : 21;
  localparam int unsigned DW   = M2 + 2;

  // Stage A: square of the scaled value.
  logic            va_q;
  logic [XW-1:0]   xa_q;
  logic [SQW-1:0]  sqa_q;
  logic [2*XW-1:0] sq_full;

  assign sq_full = {{XW{1'b0}}, x_i} * {{XW{1'b0}}, x_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    xa_q  <= x_i;
    sqa_q <= sq_full[2*XW-1:16];
  end

  // Divider pipeline: index 0 holds numerator and denominator.
  logic          v_q [0:GW];
  logic [DW-1:0] r_q [0:GW];
  logic [DW-1:0] d_q [0:GW];
  logic [GW-1:0] g_q [0:GW];

  // Stage B: numerator 42*SQ + 5*X and denominator 45*SQ + 150*X + 18.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q[0] <= DW'(42) * DW'(sqa_q) + DW'(5) * DW'(xa_q);
    d_q[0] <= DW'(45) * DW'(sqa_q) + DW'(150) * DW'(xa_q) + (DW'(18) << 16);
    g_q[0] <= '0;
  end

  // One restoring step per stage; the remainder stays below the divisor.
  for (genvar k = 0; k < GW; k++) begin : g_div
    logic [DW:0] shifted;
    logic [DW:0] diff;
    logic        ge;

    assign shifted = {r_q[k], 1'b0};
    assign ge      = shifted >= {1'b0, d_q[k]};
    assign diff    = shifted - {1'b0, d_q[k]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      r_q[k+1] <= ge ? diff[DW-1:0] : shifted[DW-1:0];
      d_q[k+1] <= d_q[k];
      g_q[k+1] <= {g_q[k][GW-2:0], ge};
    end
  end

  assign valid_o = v_q[GW];
  assign g_o     = g_q[GW];

endmodule

// File: hw/rtl/ftm_scale.sv
// ----------------------------------------------------------------------------
// ftm_scale: output scaling lane
// Forms Gc * full scale, checks it against the white point curve value for
// saturation and divides by it, one output bit per stage.
// ----------------------------------------------------------------------------
module ftm_scale (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic [ftm_pkg::CurveBits-1:0]       gc_i,
  input  logic [ftm_pkg::CurveBits-1:0]       gw_i,
  output logic                                valid_o,
  output logic [ftm_pkg::OutBits-1:0]         val_o,
  output logic                                clip_o
);

  localparam int unsigned GW = ftm_pkg::CurveBits;
  localparam int unsigned OB = ftm_pkg::OutBits;
  localparam int unsigned NW = GW + OB;

  logic          v_q [0:OB];
  logic [NW-1:0] r_q [0:OB];
  logic [GW-1:0] d_q [0:OB];
  logic          c_q [0:OB];
  logic [OB-1:0] q_q [0:OB];

  logic [NW-1:0] num;
  logic [NW-1:0] limit;

  // Saturate when Gc * full scale reaches Gw * 2^OutBits.
  assign num   = NW'(gc_i) * NW'(ftm_pkg::OutMax);
  assign limit = {gw_i, {OB{1'b0}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q[0] <= num;
    d_q[0] <= gw_i;
    c_q[0] <= (gc_i != '0) && (num >= limit);
    q_q[0] <= '0;
  end

  // Restoring division, most significant quotient bit first.
  for (genvar j = 0; j < OB; j++) begin : g_div
    logic [NW-1:0] trial;
    logic          hit;

    assign trial = NW'(d_q[j]) << (OB - 1 - j);
    assign hit   = !c_q[j] && (d_q[j] != '0) && (r_q[j] >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j+1] <= 1'b0;
      end else begin
        v_q[j+1] <= v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      r_q[j+1] <= hit ? r_q[j] - trial : r_q[j];
      d_q[j+1] <= d_q[j];
      c_q[j+1] <= c_q[j];
      q_q[j+1] <= {q_q[j][OB-2:0], hit};
    end
  end

  assign valid_o = v_q[OB];
  assign clip_o  = c_q[OB];
  assign val_o   = c_q[OB] ? OB'(ftm_pkg::OutMax) : q_q[OB];

endmodule

// File: hw/rtl/filmic_tone_mapper.sv
// ----------------------------------------------------------------------------
// filmic_tone_mapper: filmic tone mapping of linear RGB pixels
// Scales each channel by the exposure gain, applies the filmic curve,
// normalizes to the white point and saturates to 8-bit codes.
// ----------------------------------------------------------------------------
// Usage:
// - A pixel transfer happens at a clock edge with start high and busy low.
//   busy is always low, so one pixel can enter in every cycle.
// - Each pixel gives one result after the input scaling register, the curve
//   lanes, the output scaling lanes and the output register, shown for one
//   cycle with done_o. The curve divider has 32 stages and the output
//   divider 8 stages; the throughput is one pixel per clock.
// - Four curve lanes run side by side: red, green, blue and the white
//   point. Three output lanes divide by the white point curve value and
//   the output register merges their codes and clip flags.
// - The receiver cannot stall; results must be taken as they appear.
// - Configuration writes (exposure gain, white point) take effect at the next
//   edge; the user makes them only while no pixel is in flight (unenforced).
// - Reset clears the valid pipeline and loads the default gain of 1.6 and
//   white point of 11.2.
// ----------------------------------------------------------------------------
module filmic_tone_mapper #(
  parameter int unsigned FRAC_BITS = ftm_pkg::FracBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  ftm_pkg::pixel_in_t  pixel_i,
  output logic                done_o,
  output ftm_pkg::pixel_out_t result_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [23:0]         cfg_data_i
);

  localparam int unsigned XW = 44 - FRAC_BITS;
  localparam int unsigned GW = ftm_pkg::CurveBits;
  localparam int unsigned OB = ftm_pkg::OutBits;

  // Configuration registers.
  logic [15:0] gain_q;
  logic [23:0] white_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= ftm_pkg::GainReset;
      white_q <= ftm_pkg::WhiteReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ftm_pkg::CFG_EXPOSURE_GAIN: gain_q  <= cfg_data_i[15:0];
        ftm_pkg::CFG_WHITE_POINT:   white_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // Input scaling: three channels by the gain, white point by format shift.
  logic [23:0]   chan_in [0:2];
  logic [XW-1:0] x_d     [0:3];
  logic [XW-1:0] x_q     [0:3];
  logic          xv_q;

  assign chan_in[0] = pixel_i.red_in;
  assign chan_in[1] = pixel_i.green_in;
  assign chan_in[2] = pixel_i.blue_in;

  for (genvar c = 0; c < 3; c++) begin : g_gain
    logic [39:0] prod;
    assign prod   = {16'd0, chan_in[c]} * {24'd0, gain_q};
    assign x_d[c] = prod[FRAC_BITS-4 +: XW];
  end

  if (FRAC_BITS >= 16) begin : g_white_down
    assign x_d[3] = XW'(white_q[23:FRAC_BITS-16]);
  end else begin : g_white_up
    assign x_d[3] = XW'({white_q, {(16 - FRAC_BITS){1'b0}}});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xv_q <= 1'b0;
    end else begin
      xv_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
  end

  // Curve lanes.
  logic          cv  [0:3];
  logic [GW-1:0] g   [0:3];

  for (genvar c = 0; c < 4; c++) begin : g_curve
    ftm_curve #(
      .XW (XW)
    ) u_curve (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (xv_q),
      .x_i     (x_q[c]),
      .valid_o (cv[c]),
      .g_o     (g[c])
    );
  end

  // Output scaling lanes.
  logic          sv   [0:2];
  logic [OB-1:0] val  [0:2];
  logic          clip [0:2];

  for (genvar c = 0; c < 3; c++) begin : g_scale
    ftm_scale u_scale (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cv[c]),
      .gc_i    (g[c]),
      .gw_i    (g[3]),
      .valid_o (sv[c]),
      .val_o   (val[c]),
      .clip_o  (clip[c])
    );
  end

  // Merge stage: output register.
  logic                done_q;
  ftm_pkg::pixel_out_t result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= sv[0];
    end
  end

  always_ff @(posedge clk_i) begin
    result_q.red_out   <= val[0];
    result_q.green_out <= val[1];
    result_q.blue_out  <= val[2];
    result_q.clipped   <= clip[0] | clip[1] | clip[2];
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  // A clipped result shows full scale in at least one channel.
  a_clip_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.clipped |->
      (result_o.red_out == 8'(ftm_pkg::OutMax)) ||
      (result_o.green_out == 8'(ftm_pkg::OutMax)) ||
      (result_o.blue_out == 8'(ftm_pkg::OutMax)))
    else $error("clip flag without a saturated channel");

  // All curve lanes move in lockstep.
  a_curve_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cv[0] == cv[3]) && (cv[1] == cv[3]) && (cv[2] == cv[3]))
    else $error("curve lanes out of step");

  // All output lanes move in lockstep.
  a_scale_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sv[0] == sv[1]) && (sv[1] == sv[2]))
    else $error("output lanes out of step");

  // A rising done_o needs a valid pixel in the output scaling lanes before it.
  a_done_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_o) |-> $past(sv[0]))
    else $error("result without a pixel behind it");

endmodule
